// ===== hdl/dmwbc_pkg.sv =====
// package for the direct-mapped write-back cache tag store
// holds the operation codes and the transfer payload types; no dependencies
`default_nettype none

package dmwbc_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W  = 32;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_FILL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic              writeback_valid;
    logic [ADDR_W-1:0] writeback_address;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
    logic [CNT_W-1:0]  dirty_eviction_count;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/dmwbc_req_if.sv =====
// request channel of the cache tag store: valid/ready plus a req_t payload
// depends on dmwbc_pkg
`default_nettype none

interface dmwbc_req_if;
  logic              valid;
  logic              ready;
  dmwbc_pkg::req_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/dmwbc_rsp_if.sv =====
// result channel of the cache tag store: valid/ready plus an rsp_t payload
// depends on dmwbc_pkg
`default_nettype none

interface dmwbc_rsp_if;
  logic              valid;
  logic              ready;
  dmwbc_pkg::rsp_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/direct_mapped_writeback_cache_tags.sv =====
// top level of the direct-mapped write-back cache tag store
// depends on dmwbc_pkg, dmwbc_req_if and dmwbc_rsp_if
`default_nettype none

// Tag, valid and dirty store of a direct-mapped write-back cache. Each request
// is a read lookup, a write lookup or a line fill; each gives exactly one
// result carrying hit, an optional dirty writeback address and the saturating
// hit, miss and dirty-eviction totals. One request is taken per cycle unless
// the clearing pass runs or a waiting result holds the lookup stage. The set
// memory is read at the edge that takes the request; compare and update then
// load the result register once its previous result is taken. The result
// register lets the next request enter while a result waits to be taken.
// After reset the block runs a clearing pass through every set of the set
// memory, during which no request is taken. BLOCK_BYTES and SET_COUNT
// must be powers of two. Opcode 3 changes nothing and reports the totals.
module direct_mapped_writeback_cache_tags #(
  parameter int unsigned BLOCK_BYTES  = 64,
  parameter int unsigned SET_COUNT    = 1024,
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dmwbc_req_if.sink   req_i,
  dmwbc_rsp_if.source rsp_o
);
  import dmwbc_pkg::*;

  localparam int unsigned AW      = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int unsigned OFF_W   = $clog2(BLOCK_BYTES);
  localparam int unsigned IDX_W   = $clog2(SET_COUNT);
  localparam int          TAG_RAW = int'(AW) - int'(OFF_W) - int'(IDX_W);
  localparam int unsigned TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int unsigned WORD_W  = TAG_W + 2;
  localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - AW);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SET_COUNT - 1);

  // memory word: {valid, dirty, tag}
  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } line_t;

  // set memory
  logic [WORD_W-1:0] mem [SET_COUNT];

  // clearing pass
  logic             clr_busy_q;
  logic [IDX_W-1:0] clr_idx_q;

  // lookup stage
  logic             s1_valid_q;
  logic [OP_W-1:0]  s1_op_q;
  logic [IDX_W-1:0] s1_set_q;
  logic [TAG_W-1:0] s1_tag_q;
  logic [WORD_W-1:0] rd_q;
  logic             fwd_q;
  logic [WORD_W-1:0] fwd_word_q;

  // result register and totals
  logic             out_valid_q;
  rsp_t             out_q;
  logic [CNT_W-1:0] hits_q, hits_d;
  logic [CNT_W-1:0] misses_q, misses_d;
  logic [CNT_W-1:0] evict_q, evict_d;

  logic              accept, advance;
  logic [ADDR_W-1:0] in_addr;
  logic [IDX_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;
  line_t             cur;
  line_t             upd;
  logic              upd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [WORD_W-1:0] wr_word;
  logic              hit;
  logic              wb_valid;
  logic [63:0]       wb_wide;
  rsp_t              res;

  assign in_addr = req_i.data.address & ADDR_MASK;
  assign in_set  = in_addr[OFF_W +: IDX_W];
  assign in_tag  = TAG_W'(in_addr >> (OFF_W + IDX_W));

  assign advance     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !clr_busy_q && (!s1_valid_q || advance);
  assign accept      = req_i.valid && req_i.ready;

  // the write of the committing item lands on the same edge as the next read
  assign cur = line_t'(fwd_q ? fwd_word_q : rd_q);

  always_comb begin
    hit      = 1'b0;
    wb_valid = 1'b0;
    upd      = cur;
    upd_en   = 1'b0;
    hits_d   = hits_q;
    misses_d = misses_q;
    evict_d  = evict_q;
    case (s1_op_q)
      OP_READ, OP_WRITE: begin
        if (cur.valid && cur.tag == s1_tag_q) begin
          hit    = 1'b1;
          hits_d = (hits_q == '1) ? hits_q : hits_q + 1'b1;
          if (s1_op_q == OP_WRITE) begin
            upd.dirty = 1'b1;
            upd_en    = 1'b1;
          end
        end else begin
          misses_d = (misses_q == '1) ? misses_q : misses_q + 1'b1;
        end
      end
      OP_FILL: begin
        if (cur.valid && cur.dirty) begin
          wb_valid = 1'b1;
          evict_d  = (evict_q == '1) ? evict_q : evict_q + 1'b1;
        end
        upd.valid = 1'b1;
        upd.dirty = 1'b0;
        upd.tag   = s1_tag_q;
        upd_en    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // rebuilt block address of the evicted line
  assign wb_wide = (64'(cur.tag) << (OFF_W + IDX_W)) | (64'(s1_set_q) << OFF_W);

  always_comb begin
    res.hit                  = hit;
    res.writeback_valid      = wb_valid;
    res.writeback_address    = wb_valid ? wb_wide[ADDR_W-1:0] : '0;
    res.hit_count            = hits_d;
    res.miss_count           = misses_d;
    res.dirty_eviction_count = evict_d;
  end

  always_comb begin
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_idx  = clr_idx_q;
      wr_word = '0;
    end else begin
      wr_en   = advance && upd_en;
      wr_idx  = s1_set_q;
      wr_word = WORD_W'(upd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_word;
    end
    if (accept) begin
      rd_q       <= mem[in_set];
      fwd_q      <= wr_en && (wr_idx == in_set);
      fwd_word_q <= wr_word;
      s1_op_q    <= req_i.data.op;
      s1_set_q   <= in_set;
      s1_tag_q   <= in_tag;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
      evict_q     <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == LAST_IDX) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        hits_q      <= hits_d;
        misses_q    <= misses_d;
        evict_q     <= evict_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

`default_nettype wire

// ===== bench/dmwbc_tag_checker.sv =====
// transfer monitor and tag store model for the direct-mapped write-back cache
// depends on dmwbc_pkg, dmwbc_req_if and dmwbc_rsp_if
`timescale 1ns / 100ps

module dmwbc_tag_checker import dmwbc_pkg::*; #(
  parameter int unsigned BLOCK_BYTES  = 64,
  parameter int unsigned SET_COUNT    = 1024,
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dmwbc_req_if        req_mon,
  dmwbc_rsp_if        rsp_mon,
  output int unsigned mismatch_count,
  output int unsigned outstanding
);

  localparam int unsigned OFFSET_W = $clog2(BLOCK_BYTES);
  localparam int unsigned SET_W    = $clog2(SET_COUNT);
  localparam int unsigned TAG_W    = ADDRESS_BITS - OFFSET_W - SET_W;
  localparam int unsigned MAX_SHOWN = 50;

  logic [TAG_W-1:0] line_tag   [SET_COUNT];
  logic             line_valid [SET_COUNT];
  logic             line_dirty [SET_COUNT];
  logic [CNT_W-1:0] hits_seen;
  logic [CNT_W-1:0] misses_seen;
  logic [CNT_W-1:0] dirty_evictions_seen;

  rsp_t cache_outcome_q [$];

  function automatic logic [CNT_W-1:0] bump_saturating(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // updates the tag store for one access and returns what the block must answer
  function automatic rsp_t apply_access(req_t acc);
    rsp_t             outcome;
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag_val;
    outcome = '0;
    set_idx = acc.address[OFFSET_W +: SET_W];
    tag_val = acc.address[OFFSET_W + SET_W +: TAG_W];
    case (acc.op)
      OP_READ, OP_WRITE: begin
        // tag is looked at only on a valid line, so unwritten tags never matter
        if (line_valid[set_idx] && line_tag[set_idx] == tag_val) begin
          outcome.hit = 1'b1;
          hits_seen = bump_saturating(hits_seen);
          if (acc.op == OP_WRITE) line_dirty[set_idx] = 1'b1;
        end else begin
          misses_seen = bump_saturating(misses_seen);
        end
      end
      OP_FILL: begin
        if (line_valid[set_idx] && line_dirty[set_idx]) begin
          outcome.writeback_valid   = 1'b1;
          outcome.writeback_address = ADDR_W'({line_tag[set_idx], set_idx, OFFSET_W'(0)});
          dirty_evictions_seen = bump_saturating(dirty_evictions_seen);
        end
        line_tag[set_idx]   = tag_val;
        line_valid[set_idx] = 1'b1;
        line_dirty[set_idx] = 1'b0;
      end
      default: ;
    endcase
    outcome.hit_count            = hits_seen;
    outcome.miss_count           = misses_seen;
    outcome.dirty_eviction_count = dirty_evictions_seen;
    return outcome;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", field, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t got;
    rsp_t want;
    if (!rst_ni) begin
      line_valid           = '{default: 1'b0};
      line_dirty           = '{default: 1'b0};
      hits_seen            = '0;
      misses_seen          = '0;
      dirty_evictions_seen = '0;
      mismatch_count       = 0;
      cache_outcome_q.delete();
      outstanding <= 0;
    end else begin
      // the result side goes first: a result always belongs to an older access
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.data;
        if (cache_outcome_q.size() == 0) begin
          report_mismatch("result transfer with no access pending");
        end else begin
          want = cache_outcome_q.pop_front();
          compare_field("hit", 32'(got.hit), 32'(want.hit));
          compare_field("writeback_valid", 32'(got.writeback_valid),
                        32'(want.writeback_valid));
          compare_field("writeback_address", got.writeback_address,
                        want.writeback_address);
          compare_field("hit_count", got.hit_count, want.hit_count);
          compare_field("miss_count", got.miss_count, want.miss_count);
          compare_field("dirty_eviction_count", got.dirty_eviction_count,
                        want.dirty_eviction_count);
        end
      end
      if (req_mon.valid && req_mon.ready) cache_outcome_q.push_back(apply_access(req_mon.data));
      outstanding <= cache_outcome_q.size();
    end
  end

endmodule

// ===== bench/tb_direct_mapped_writeback_cache_tags.sv =====
// top of the cache tag store bench: clock, reset, access traffic and verdict
// depends on dmwbc_pkg, both channel interfaces, the block and dmwbc_tag_checker
`timescale 1ns / 100ps

module tb_direct_mapped_writeback_cache_tags;
  import dmwbc_pkg::*;

  localparam int unsigned BLOCK_BYTES    = 64;
  localparam int unsigned SET_COUNT      = 1024;
  localparam int unsigned ADDRESS_BITS   = 32;
  localparam int unsigned PHASE_ACCESSES = 460;
  localparam int unsigned CYCLE_LIMIT    = 300000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  int unsigned sender_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycle_count;

  dmwbc_req_if req_ch ();
  dmwbc_rsp_if rsp_ch ();

  direct_mapped_writeback_cache_tags #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .SET_COUNT   (SET_COUNT),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  dmwbc_tag_checker #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .SET_COUNT   (SET_COUNT),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_ch),
    .rsp_mon       (rsp_ch),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("direct_mapped_writeback_cache_tags test failed");
    $finish;
  end

  // holds the access until the block takes it; the sender may pause first
  task automatic send_access(input logic [OP_W-1:0] acc_op, input logic [ADDR_W-1:0] acc_addr);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= req_t'{op: acc_op, address: acc_addr};
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  initial begin
    int unsigned      pick;
    logic [OP_W-1:0]  acc_op;
    logic [ADDR_W-1:0] acc_addr;
    logic [15:0]      tag_part;
    logic [9:0]       set_part;
    logic [5:0]       offset_part;

    sender_idle_pct = 0;
    sink_idle_pct   = 0;
    rst_ni        = 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: cold misses, unused opcode, clean and dirty evictions at both ends
    send_access(OP_READ,   32'h0000_0000);
    send_access(OP_WRITE,  32'hFFFF_FFFF);
    send_access(OP_UNUSED, 32'h1234_5678);
    send_access(OP_FILL,   32'h0000_0000);
    send_access(OP_READ,   32'h0000_003F);
    send_access(OP_WRITE,  32'h0000_0010);
    // dirty line with tag and set zero: writeback of address zero
    send_access(OP_FILL,   32'h0001_0000);
    send_access(OP_READ,   32'h0000_0000);
    send_access(OP_READ,   32'h0001_0004);
    // clean occupant, no writeback
    send_access(OP_FILL,   32'h0002_0000);
    send_access(OP_FILL,   32'hFFFF_FFC0);
    send_access(OP_WRITE,  32'hFFFF_FFFF);
    send_access(OP_READ,   32'hFFFF_FFC0);
    send_access(OP_FILL,   32'h0000_FFC0);
    send_access(OP_WRITE,  32'h0000_FFC1);
    // refill of the same block while dirty still writes it back
    send_access(OP_FILL,   32'h0000_FFC0);
    send_access(OP_UNUSED, 32'hFFFF_FFFF);
    send_access(OP_FILL,   32'hAAAA_AA80);
    send_access(OP_WRITE,  32'h5555_AA95);
    send_access(OP_WRITE,  32'hAAAA_AABF);
    send_access(OP_FILL,   32'h5555_AA80);
    send_access(OP_READ,   32'h5555_AAFF);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 15;
          sink_idle_pct   = 88;
        end
        1: begin
          sender_idle_pct = 88;
          sink_idle_pct   = 15;
        end
        default: begin
          sender_idle_pct = 0;
          sink_idle_pct   = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ACCESSES; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 38) acc_op = OP_READ;
        else if (pick < 73) acc_op = OP_WRITE;
        else if (pick < 95) acc_op = OP_FILL;
        else acc_op = OP_UNUSED;
        // mostly a small pool of sets and tags so lines get reused and evicted
        if ($urandom_range(0, 9) == 0) begin
          acc_addr = $urandom;
        end else begin
          tag_part    = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
          set_part    = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
          offset_part = 6'($urandom);
          acc_addr    = {tag_part, set_part, offset_part};
        end
        send_access(acc_op, acc_addr);
      end
    end
    req_ch.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("direct_mapped_writeback_cache_tags test passed");
    end else begin
      $display("direct_mapped_writeback_cache_tags test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dmwbc_pkg.sv
hdl/dmwbc_req_if.sv
hdl/dmwbc_rsp_if.sv
hdl/direct_mapped_writeback_cache_tags.sv
bench/dmwbc_tag_checker.sv
bench/tb_direct_mapped_writeback_cache_tags.sv
